// ===== hw/rtl/wprf_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants, codes and transaction types of the written-page read filter.
package wprf_pkg;

	localparam int MAX_PAGES       = 1048576;
	localparam int MAX_REQ_SECTORS = 256;
	localparam int PAGE_SHIFT      = 3;
	localparam int WORD_BITS       = 64;
	localparam int MAP_WORDS       = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W           = $clog2(WORD_BITS);
	localparam int PAGE_W          = $clog2(MAX_PAGES);
	localparam int BOUND_W         = PAGE_W + 1;
	localparam int EXT_W           = BOUND_W + 1;
	localparam int CNT_W           = 32;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAGES    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ATTACHED = 1'b1;

	typedef enum logic [3:0] {
		ACT_WRITE   = 4'd0,
		ACT_READ    = 4'd1,
		ACT_TEST    = 4'd2,
		ACT_SET_PG  = 4'd3,
		ACT_CLR_PG  = 4'd4,
		ACT_SET_RNG = 4'd5,
		ACT_CLR_RNG = 4'd6,
		ACT_SET_ALL = 4'd7,
		ACT_CLR_ALL = 4'd8,
		ACT_RST_CNT = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_DEV  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_SET,
		CMD_CLR,
		CMD_WRITE,
		CMD_READ,
		CMD_TEST,
		CMD_RST_CNT
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_WALK,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		status_t            status;
		logic               span_en;
		logic [PAGE_W-1:0]  first_pg;
		logic [PAGE_W-1:0]  last_pg;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic               forward;
		logic               marked;
		logic [CNT_W-1:0]   writes;
		logic [CNT_W-1:0]   reads;
		logic [CNT_W-1:0]   filtered;
	} res_t;

endpackage

// ===== hw/rtl/wprf_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module wprf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/wprf_front.sv =====
`timescale 1ns / 1ps
// Front end: bound checks and classification of an incoming item into a map command.
module wprf_front (
	input  logic [3:0]                    action,
	input  logic [22:0]                   start_sector,
	input  logic [8:0]                    sector_count,
	input  logic [wprf_pkg::PAGE_W-1:0]   page_index,
	input  logic [wprf_pkg::BOUND_W-1:0]  range_length,
	input  logic [wprf_pkg::BOUND_W-1:0]  map_pages,
	input  logic                          device_attached,
	output wprf_pkg::cmd_t                cmd
);

	logic [wprf_pkg::BOUND_W-1:0] bound;
	logic [wprf_pkg::EXT_W-1:0]   bound_x;
	logic [wprf_pkg::PAGE_W-1:0]  req_first;
	logic [5:0]                   req_pages;
	logic [wprf_pkg::EXT_W-1:0]   req_end;
	logic [wprf_pkg::EXT_W-1:0]   pg_end;
	logic [wprf_pkg::EXT_W-1:0]   rng_end;
	logic [wprf_pkg::EXT_W-1:0]   end_v;
	logic [wprf_pkg::PAGE_W-1:0]  first_v;
	logic                         pg_bad;

	always_comb begin
		bound = (map_pages > wprf_pkg::BOUND_W'(wprf_pkg::MAX_PAGES)) ?
			wprf_pkg::BOUND_W'(wprf_pkg::MAX_PAGES) : map_pages;
		bound_x   = {1'b0, bound};
		req_first = start_sector[22:wprf_pkg::PAGE_SHIFT];
		req_pages = sector_count[8:wprf_pkg::PAGE_SHIFT];
		req_end   = wprf_pkg::EXT_W'(req_first) + wprf_pkg::EXT_W'(req_pages);
		pg_end    = wprf_pkg::EXT_W'(page_index) + wprf_pkg::EXT_W'(1);
		rng_end   = wprf_pkg::EXT_W'(page_index) + wprf_pkg::EXT_W'(range_length);
		pg_bad    = wprf_pkg::EXT_W'(page_index) >= bound_x;

		cmd.kind   = wprf_pkg::CMD_NOP;
		cmd.status = wprf_pkg::ST_OK;
		first_v    = '0;
		end_v      = '0;

		case (action)
			wprf_pkg::ACT_WRITE, wprf_pkg::ACT_READ: begin
				if (!device_attached) begin
					cmd.status = wprf_pkg::ST_NO_DEV;
				end else if (sector_count > 9'(wprf_pkg::MAX_REQ_SECTORS) ||
						req_end > bound_x) begin
					cmd.status = wprf_pkg::ST_INVALID;
				end else begin
					cmd.kind = (action == wprf_pkg::ACT_WRITE) ?
						wprf_pkg::CMD_WRITE : wprf_pkg::CMD_READ;
					first_v = req_first;
					end_v   = req_end;
				end
			end
			wprf_pkg::ACT_TEST, wprf_pkg::ACT_SET_PG, wprf_pkg::ACT_CLR_PG: begin
				if (pg_bad) begin
					cmd.status = wprf_pkg::ST_INVALID;
				end else begin
					cmd.kind = (action == wprf_pkg::ACT_TEST) ? wprf_pkg::CMD_TEST :
						(action == wprf_pkg::ACT_SET_PG) ? wprf_pkg::CMD_SET :
						wprf_pkg::CMD_CLR;
					first_v = page_index;
					end_v   = pg_end;
				end
			end
			wprf_pkg::ACT_SET_RNG, wprf_pkg::ACT_CLR_RNG: begin
				if (pg_bad || rng_end > bound_x) begin
					cmd.status = wprf_pkg::ST_INVALID;
				end else begin
					cmd.kind = (action == wprf_pkg::ACT_SET_RNG) ?
						wprf_pkg::CMD_SET : wprf_pkg::CMD_CLR;
					first_v = page_index;
					end_v   = rng_end;
				end
			end
			wprf_pkg::ACT_SET_ALL, wprf_pkg::ACT_CLR_ALL: begin
				cmd.kind = (action == wprf_pkg::ACT_SET_ALL) ?
					wprf_pkg::CMD_SET : wprf_pkg::CMD_CLR;
				end_v = bound_x;
			end
			wprf_pkg::ACT_RST_CNT: begin
				cmd.kind = wprf_pkg::CMD_RST_CNT;
			end
			default: begin
				cmd.status = wprf_pkg::ST_INVALID;
			end
		endcase

		// empty spans (short requests, zero-length ranges) touch no map word
		cmd.span_en  = end_v > wprf_pkg::EXT_W'(first_v);
		cmd.first_pg = first_v;
		cmd.last_pg  = wprf_pkg::PAGE_W'(end_v - wprf_pkg::EXT_W'(1));
	end

endmodule

// ===== hw/rtl/wprf_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the map engine.
module wprf_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  wprf_pkg::cmd_t din,
	output logic           full,
	input  logic           rd_en,
	output wprf_pkg::cmd_t dout,
	output logic           empty
);

	wprf_pkg::cmd_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= din;
		end
	end

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rptr_q];

endmodule

// ===== hw/rtl/wprf_back.sv =====
`timescale 1ns / 1ps
// Map engine: page bitmap RAM, word walk for spans, counters and result queue.
module wprf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  wprf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_pop,
	output logic           res_empty,
	output wprf_pkg::res_t res,
	output logic           clearing
);

	localparam int AW = $clog2(wprf_pkg::MAP_WORDS);

	wprf_pkg::back_state_t       state_q, state_nxt;
	wprf_pkg::cmd_t              cmd_q;
	logic [AW-1:0]               word_q, word_nxt;
	logic                        any_q, any_nxt;
	logic [AW-1:0]               clr_addr_q;
	logic [wprf_pkg::CNT_W-1:0]  wc_q, rc_q, fc_q;
	logic [wprf_pkg::CNT_W-1:0]  wc_n, rc_n, fc_n;
	logic                        load_cmd;

	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [wprf_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0]               first_w, last_w;
	logic [wprf_pkg::BIT_W-1:0]  lo, hi;
	logic [wprf_pkg::WORD_BITS-1:0] mask;
	logic                        hit;

	wprf_pkg::cmd_t              fin_cmd;
	logic                        fin_any;
	logic                        res_push;
	wprf_pkg::res_t              res_d;
	wprf_pkg::res_t              res_mem_q [2];
	logic                        rwp_q, rrp_q;
	logic [1:0]                  rcnt_q;
	logic                        res_full;

	wprf_ram #(
		.WIDTH(wprf_pkg::WORD_BITS),
		.DEPTH(wprf_pkg::MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// bit mask of the current word covered by the span
	always_comb begin
		first_w = cmd_q.first_pg[wprf_pkg::PAGE_W-1:wprf_pkg::BIT_W];
		last_w  = cmd_q.last_pg[wprf_pkg::PAGE_W-1:wprf_pkg::BIT_W];
		lo = (word_q == first_w) ? cmd_q.first_pg[wprf_pkg::BIT_W-1:0] : '0;
		hi = (word_q == last_w) ? cmd_q.last_pg[wprf_pkg::BIT_W-1:0] : '1;
		mask = ({wprf_pkg::WORD_BITS{1'b1}} << lo) &
			({wprf_pkg::WORD_BITS{1'b1}} >>
			(wprf_pkg::BIT_W'(wprf_pkg::WORD_BITS - 1) - hi));
		hit = |(ram_rdata & mask);
	end

	assign res_full = rcnt_q == 2'd2;
	assign clearing = state_q == wprf_pkg::BK_CLEAR;

	always_comb begin
		state_nxt = state_q;
		cmd_pop   = 1'b0;
		load_cmd  = 1'b0;
		word_nxt  = word_q;
		any_nxt   = any_q;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = (cmd_q.kind == wprf_pkg::CMD_CLR) ? (ram_rdata & ~mask) :
			(ram_rdata | mask);
		ram_re    = 1'b0;
		ram_raddr = cmd.first_pg[wprf_pkg::PAGE_W-1:wprf_pkg::BIT_W];
		res_push  = 1'b0;
		fin_cmd   = cmd_q;
		fin_any   = any_q;

		case (state_q)
			wprf_pkg::BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) begin
					state_nxt = wprf_pkg::BK_IDLE;
				end
			end
			wprf_pkg::BK_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.span_en) begin
						load_cmd  = 1'b1;
						ram_re    = 1'b1;
						word_nxt  = ram_raddr;
						any_nxt   = 1'b0;
						state_nxt = wprf_pkg::BK_WALK;
					end else begin
						res_push = 1'b1;
						fin_cmd  = cmd;
						fin_any  = 1'b0;
					end
				end
			end
			wprf_pkg::BK_WALK: begin
				ram_we = cmd_q.kind inside {wprf_pkg::CMD_SET, wprf_pkg::CMD_CLR,
					wprf_pkg::CMD_WRITE};
				if (word_q == last_w) begin
					fin_any = any_q | hit;
					any_nxt = any_q | hit;
					if (!res_full) begin
						res_push  = 1'b1;
						state_nxt = wprf_pkg::BK_IDLE;
					end else begin
						state_nxt = wprf_pkg::BK_FIN;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = word_q + AW'(1);
					word_nxt  = word_q + AW'(1);
					any_nxt   = any_q | hit;
				end
			end
			wprf_pkg::BK_FIN: begin
				if (!res_full) begin
					res_push  = 1'b1;
					state_nxt = wprf_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nxt = wprf_pkg::BK_IDLE;
			end
		endcase
	end

	// result and counters after this transaction
	always_comb begin
		wc_n = wc_q;
		rc_n = rc_q;
		fc_n = fc_q;
		res_d.status  = fin_cmd.status;
		res_d.forward = 1'b0;
		res_d.marked  = 1'b0;
		case (fin_cmd.kind)
			wprf_pkg::CMD_WRITE: begin
				res_d.forward = 1'b1;
				wc_n = wc_q + 32'd1;
			end
			wprf_pkg::CMD_READ: begin
				if (fin_any) begin
					res_d.forward = 1'b1;
					rc_n = rc_q + 32'd1;
				end else begin
					fc_n = fc_q + 32'd1;
				end
			end
			wprf_pkg::CMD_TEST: begin
				res_d.marked = fin_any;
			end
			wprf_pkg::CMD_RST_CNT: begin
				wc_n = '0;
				rc_n = '0;
				fc_n = '0;
			end
			default: begin
			end
		endcase
		res_d.writes   = wc_n;
		res_d.reads    = rc_n;
		res_d.filtered = fc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wprf_pkg::BK_CLEAR;
			clr_addr_q <= '0;
			wc_q       <= '0;
			rc_q       <= '0;
			fc_q       <= '0;
			rwp_q      <= 1'b0;
			rrp_q      <= 1'b0;
			rcnt_q     <= 2'd0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wprf_pkg::BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (res_push) begin
				wc_q  <= wc_n;
				rc_q  <= rc_n;
				fc_q  <= fc_n;
				rwp_q <= ~rwp_q;
			end
			if (res_pop && !res_empty) begin
				rrp_q <= ~rrp_q;
			end
			rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, res_pop && !res_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= cmd;
		end
		word_q <= word_nxt;
		any_q  <= any_nxt;
		if (res_push) begin
			res_mem_q[rwp_q] <= res_d;
		end
	end

	assign res_empty = rcnt_q == 2'd0;
	assign res       = res_mem_q[rrp_q];

endmodule

// ===== hw/rtl/written_page_read_filter.sv =====
`timescale 1ns / 1ps
// Written-page read filter top level: config registers, front end, command queue, map engine.
//
// One bit per 4 KiB page (8 sectors) records whether the page was ever written; the map
// holds 16384 words of 64 pages in a single RAM. After reset the engine sweeps the RAM to
// zero, one word per cycle, and full stays high for the whole sweep; configuration writes
// are taken during that time. A transaction that touches no map word (status-only answers,
// counter reset, empty spans) is answered straight from idle; one that touches map words
// walks the covered 64-page words in order, reading each word and writing it back for
// writes, sets and clears, over the full map for set all or clear all. The engine takes a
// new command only when idle and with room in the result queue. A two-entry command queue
// and a two-entry result queue let input and output stall independently.
module written_page_read_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [3:0]                    action,
	input  logic [22:0]                   start_sector,
	input  logic [8:0]                    sector_count,
	input  logic [wprf_pkg::PAGE_W-1:0]   page_index,
	input  logic [wprf_pkg::BOUND_W-1:0]  range_length,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic                          forward,
	output logic                          page_marked,
	output logic [wprf_pkg::CNT_W-1:0]    writes_count,
	output logic [wprf_pkg::CNT_W-1:0]    reads_count,
	output logic [wprf_pkg::CNT_W-1:0]    filtered_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wprf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wprf_pkg::BOUND_W-1:0]  cfg_data
);

	logic [wprf_pkg::BOUND_W-1:0] map_pages_q;
	logic                         device_attached_q;
	wprf_pkg::cmd_t               cmd_in, cmd_out;
	logic                         cmd_full, cmd_empty, cmd_pop;
	logic                         clearing;
	logic                         push_ok;
	wprf_pkg::res_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_pages_q       <= wprf_pkg::BOUND_W'(wprf_pkg::MAX_PAGES);
			device_attached_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wprf_pkg::CFG_MAP_PAGES:    map_pages_q <= cfg_data;
				wprf_pkg::CFG_DEV_ATTACHED: device_attached_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign full    = cmd_full || clearing;
	assign push_ok = push && !full;

	wprf_front u_front (
		.action         (action),
		.start_sector   (start_sector),
		.sector_count   (sector_count),
		.page_index     (page_index),
		.range_length   (range_length),
		.map_pages      (map_pages_q),
		.device_attached(device_attached_q),
		.cmd            (cmd_in)
	);

	wprf_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (push_ok),
		.din   (cmd_in),
		.full  (cmd_full),
		.rd_en (cmd_pop),
		.dout  (cmd_out),
		.empty (cmd_empty)
	);

	wprf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_pop  (pop),
		.res_empty(empty),
		.res      (res),
		.clearing (clearing)
	);

	assign status         = res.status;
	assign forward        = res.forward;
	assign page_marked    = res.marked;
	assign writes_count   = res.writes;
	assign reads_count    = res.reads;
	assign filtered_count = res.filtered;

	a_fwd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && forward) |-> (status == wprf_pkg::ST_OK))
		else $error("forwarded transaction without ok status");

	a_mark_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && page_marked) |-> (!forward && status == wprf_pkg::ST_OK))
		else $error("marked page on a non-test result");

	a_nodev: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == wprf_pkg::ST_NO_DEV) |-> !device_attached_q)
		else $error("no-device status while device attached");

endmodule
